/* hw/rtl/scancode_to_ascii_fifo_assert.svh */
// assertion macros used by the keyboard queue rtl
`ifndef SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`define SCANCODE_TO_ASCII_FIFO_ASSERT_SVH

// same-cycle implication, disabled during reset
`define STA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyboard queue check failed");

// next-cycle implication, disabled during reset
`define STA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyboard queue check failed");

`endif

/* hw/rtl/sta_pkg.sv */
package sta_pkg;

   // character queue
   localparam int QUEUE_DEPTH = 128;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CHAR_W      = 7;

   // command queue between front and back
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

   // controller status and scancode decoding
   localparam logic READY_MASK = 1'b1;
   localparam int   TABLE_SIZE = 58;
   localparam int   IDX_W      = $clog2(TABLE_SIZE);

   typedef enum logic [0:0] {
      OP_READ = 1'b0,
      OP_POLL = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CMD_PUSH = 1'b0,
      CMD_POLL = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] ch;
   } cmd_type;

   typedef enum logic [0:0] {
      BK_IDLE = 1'b0,
      BK_READ = 1'b1
   } bk_state_type;

   // set-1 make codes to ascii, zero where no character
   localparam logic [CHAR_W-1:0] SET1_ASCII [TABLE_SIZE] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2d, 7'h3d, 7'h00, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
      7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
      7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20
   };

endpackage

/* hw/rtl/sta_ram.sv */
module sta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sta_front.sv */
module sta_front (
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_operation,
   input  logic            req_data_ready,
   input  logic [7:0]      req_scancode,
   output logic            cmd_valid,
   input  logic            cmd_ready,
   output sta_pkg::cmd_type cmd
);

   import sta_pkg::*;

   logic              in_table;
   logic [CHAR_W-1:0] mapped;
   logic              is_poll;

   // make codes inside the table only; break codes have bit 7 set
   assign in_table = ((req_data_ready & READY_MASK) != 1'b0)
                     && (req_scancode < 8'(TABLE_SIZE));
   assign mapped   = in_table ? SET1_ASCII[req_scancode[IDX_W-1:0]] : '0;
   assign is_poll  = (op_type'(req_operation) == OP_POLL);

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid && (is_poll || (mapped != '0));

   always_comb begin
      cmd.kind = is_poll ? CMD_POLL : CMD_PUSH;
      cmd.ch   = mapped;
   end

endmodule

/* hw/rtl/sta_cmdq.sv */
module sta_cmdq (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  sta_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output sta_pkg::cmd_type out_cmd
);

   import sta_pkg::*;

   cmd_type               slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  push, pop;

   assign in_ready  = (cnt_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

/* hw/rtl/sta_back.sv */
module sta_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  sta_pkg::cmd_type          cmd,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [sta_pkg::CHAR_W-1:0] rsp_ascii_char,
   output logic                      rsp_char_valid
);

   import sta_pkg::*;

   bk_state_type      state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_cv_ff, rsp_cv_in;
   logic [CHAR_W-1:0] rd_data;

   logic rsp_free, take, is_poll, push_do, pop_do, empty_poll;

   assign is_poll    = (cmd.kind == CMD_POLL);
   assign take       = cmd_valid && cmd_ready;
   assign push_do    = take && !is_poll && (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_do     = take && is_poll && (count_ff != '0);
   assign empty_poll = take && is_poll && (count_ff == '0);

   sta_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (push_do),
      .wr_addr(tail_ff),
      .wr_data(cmd.ch),
      .rd_en  (pop_do),
      .rd_addr(head_ff),
      .rd_data(rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (pop_do) state_in = BK_READ;
         BK_READ: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      rsp_free     = !rsp_valid_ff || rsp_ready;
      cmd_ready    = (state_ff == BK_IDLE) && rsp_free;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_cv_in    = rsp_cv_ff;
      if (push_do) begin
         tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (pop_do) begin
         head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      priority if (state_ff == BK_READ) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = rd_data;
         rsp_cv_in    = 1'b1;
      end else if (empty_poll) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = '0;
         rsp_cv_in    = 1'b0;
      end else begin
         rsp_char_in  = rsp_char_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_cv_ff   <= rsp_cv_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_char_valid = rsp_cv_ff;

endmodule

/* hw/rtl/scancode_to_ascii_fifo.sv */
// keyboard scancode translator with a character queue. an item is either a
// controller read (operation 0) carrying the status ready bit and a set-1
// scancode, or a poll (operation 1). a read with ready set and a make code
// that maps to a character appends it to a 128-entry queue, dropped when the
// queue is full; reads give no result. each poll gives one result: the
// oldest character with char_valid 1, or 0 with char_valid 0 when empty.
// the front decodes the scancode combinationally through a constant table
// and hands a command to a two-entry queue; the back runs the ring buffer.
// reads and empty polls finish in the idle state; a poll that finds a
// character goes on to a read state, as the store is a ram with a registered
// read port. the queue is empty right after reset, with no clearing pass.
module scancode_to_ascii_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  logic                      req_data_ready,
   input  logic [7:0]                req_scancode,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [sta_pkg::CHAR_W-1:0] rsp_ascii_char,
   output logic                      rsp_char_valid
);

   import sta_pkg::*;

   `include "scancode_to_ascii_fifo_assert.svh"

   // front to command queue
   logic    fq_valid, fq_ready;
   cmd_type fq_cmd;

   // command queue to back
   logic    qb_valid, qb_ready;
   cmd_type qb_cmd;

   // decode: drops reads that carry no character
   sta_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_data_ready(req_data_ready),
      .req_scancode  (req_scancode),
      .cmd_valid     (fq_valid),
      .cmd_ready     (fq_ready),
      .cmd           (fq_cmd)
   );

   // short queue lets the front keep taking items while the back waits on ram
   sta_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fq_valid),
      .in_ready (fq_ready),
      .in_cmd   (fq_cmd),
      .out_valid(qb_valid),
      .out_ready(qb_ready),
      .out_cmd  (qb_cmd)
   );

   // ring buffer, character store and result register
   sta_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (qb_valid),
      .cmd_ready     (qb_ready),
      .cmd           (qb_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ascii_char(rsp_ascii_char),
      .rsp_char_valid(rsp_char_valid)
   );

   // an empty poll returns a zero character
   `STA_ASSERT_NOW(a_empty_is_zero, clock, reset,
      rsp_valid && !rsp_char_valid, rsp_ascii_char == '0)

   // a dequeued character is never zero, since zero codes are not queued
   `STA_ASSERT_NOW(a_char_nonzero, clock, reset,
      rsp_valid && rsp_char_valid, rsp_ascii_char != '0)

   // the back takes no command while a result is stalled
   `STA_ASSERT_NOW(a_no_take_on_stall, clock, reset,
      rsp_valid && !rsp_ready, !(qb_valid && qb_ready))

   // a stalled result stays on the port
   `STA_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ascii_char))

endmodule
